/* src/r2fft_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the radix-2 fixed-point FFT unit.
// Depends on nothing; used by r2fft_bfly and radix2_fixed_point_fft_unit.
package r2fft_pkg;

	// One complex word, real part in the low half.
	typedef struct packed {
		logic signed [31:0] im;
		logic signed [31:0] re;
	} cword_t;

	// Request kinds carried on s_tuser.
	localparam logic [1:0] ACT_TWIDDLE = 2'd0;
	localparam logic [1:0] ACT_SAMPLE  = 2'd1;
	localparam logic [1:0] ACT_RUN     = 2'd2;
	localparam logic [1:0] ACT_READ    = 2'd3;

	// Fixed point format: Q10.
	localparam int unsigned FRAC_BITS = 10;

endpackage

/* src/r2fft_bfly.sv */
`timescale 1ns / 1ps
// Butterfly arithmetic for the FFT unit: one shared 32x32 multiplier walks
// the eight partial products of e + W*o and e + (-W)*o. Uses r2fft_pkg.
module r2fft_bfly (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  r2fft_pkg::cword_t     e_in,
	input  r2fft_pkg::cword_t     o_in,
	input  r2fft_pkg::cword_t     w_in,
	output logic                  done,
	output r2fft_pkg::cword_t     even,
	output r2fft_pkg::cword_t     odd
);

	r2fft_pkg::cword_t e_q, o_q, w_q;
	logic              run_q;
	logic [2:0]        cnt_q;
	logic              pv_s1;
	logic [2:0]        pidx_s1;
	logic signed [63:0] prod_s1;
	logic signed [31:0] xr_q, xi_q, yr_q, yi_q;
	logic              done_q;

	logic signed [31:0] nwr, nwi, op_a, op_b, t;

	assign nwr = -w_q.re;
	assign nwi = -w_q.im;

	// Products 0..3 use W, 4..7 use the negated W.
	always_comb begin
		case (cnt_q)
			3'd0: begin op_a = w_q.re; op_b = o_q.re; end
			3'd1: begin op_a = w_q.im; op_b = o_q.im; end
			3'd2: begin op_a = w_q.re; op_b = o_q.im; end
			3'd3: begin op_a = w_q.im; op_b = o_q.re; end
			3'd4: begin op_a = nwr;    op_b = o_q.re; end
			3'd5: begin op_a = nwi;    op_b = o_q.im; end
			3'd6: begin op_a = nwr;    op_b = o_q.im; end
			default: begin op_a = nwi; op_b = o_q.re; end
		endcase
	end

	// Arithmetic shift right by the fraction width, low 32 bits kept.
	assign t = prod_s1[r2fft_pkg::FRAC_BITS +: 32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			pv_s1  <= run_q;
			done_q <= pv_s1 && (pidx_s1 == 3'd7);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			e_q <= e_in;
			o_q <= o_in;
			w_q <= w_in;
		end
		prod_s1 <= op_a * op_b;
		pidx_s1 <= cnt_q;
		if (pv_s1) begin
			case (pidx_s1)
				3'd0: xr_q <= t;
				3'd1: xr_q <= xr_q - t;
				3'd2: xi_q <= t;
				3'd3: xi_q <= xi_q + t;
				3'd4: yr_q <= t;
				3'd5: yr_q <= yr_q - t;
				3'd6: yi_q <= t;
				default: yi_q <= yi_q + t;
			endcase
		end
	end

	assign done    = done_q;
	assign even.re = e_q.re + xr_q;
	assign even.im = e_q.im + xi_q;
	assign odd.re  = e_q.re + yr_q;
	assign odd.im  = e_q.im + yi_q;

endmodule

/* src/radix2_fixed_point_fft_unit.sv */
`timescale 1ns / 1ps
// Top level of the radix-2 decimation-in-time FFT unit (Q10 fixed point).
// Uses r2fft_pkg and r2fft_bfly; holds the data and twiddle memories.
//
// Usage: every request arrives on the s_ stream, its kind on s_tuser. A
// twiddle write stores W^index; a sample write stores a real sample at the
// bit-reversed address with a zero imaginary part; a run request transforms
// the loaded data in place; a read request returns one bin on the m_ stream.
// The transform length 2^size_log2 is set through the cfg channel, which is
// always ready and must only be written while the unit is idle.
// Twiddle and sample writes never lower s_tready. A read result is registered
// in the read data register and then in the output register; s_tready is low
// while the read is pending. A run request keeps s_tready low until all
// L * 2^(L-1) butterflies are done (L the effective size); each butterfly is
// paced by the single shared multiplier that forms eight partial products in
// turn and by the single data memory write port, which takes even and odd in turn.
// If the receiver stalls, one more read result parks in a hold register and
// s_tready then drops until the hold register empties; write requests still
// flow while just the output register is full. Reset clears the control state
// and sets size_log2 to 10; memories are undefined until written, not cleared.
module radix2_fixed_point_fft_unit #(
	parameter int MAX_LOG2 = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,   // size_log2
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,    // index[9:0], value_real[41:10], value_imag[73:42], zeros
	input  logic [1:0]  s_tuser,    // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata     // bin_real[31:0], bin_imag[63:32]
);

	localparam int AW  = MAX_LOG2;
	localparam int TWA = (MAX_LOG2 > 1) ? MAX_LOG2 - 1 : 1;
	localparam int LW  = $clog2(MAX_LOG2 + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_WAIT = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_WE   = 3'd4;
	localparam logic [2:0] ST_WO   = 3'd5;

	r2fft_pkg::cword_t data_mem [2**AW];
	r2fft_pkg::cword_t tw_mem   [2**TWA];

	logic [3:0]    size_q;
	logic [2:0]    st_q;
	logic [LW-1:0] stage_q;
	logic [TWA-1:0] bfly_q;
	logic          rd_pend_q;
	logic          m_valid_q, hold_v_q;
	r2fft_pkg::cword_t out_q, hold_q, rda_q, rdb_q, rdw_q;

	logic [LW-1:0] l_eff;
	logic [AW:0]   nbit;
	logic [AW-1:0] nmask, idx_a, idx_rev, bin_addr, smp_addr;
	logic [TWA:0]  tbit;
	logic [TWA-1:0] twm, tw_wr_addr, tw_rd_addr;
	logic [AW-1:0] hbit, hm, bx, jv, ei, oi, tw_full;
	logic          acc, last_bfly;
	logic [1:0]    action;
	r2fft_pkg::cword_t in_word, smp_word;
	logic          wr_en;
	logic [AW-1:0] wr_addr, rda_addr;
	r2fft_pkg::cword_t wr_data;
	logic          bf_done;
	r2fft_pkg::cword_t bf_even, bf_odd;

	assign cfg_ready = 1'b1;

	// Out-of-range sizes fold into 1..MAX_LOG2.
	always_comb begin
		if (size_q == 4'd0) begin
			l_eff = LW'(1);
		end else if (32'(size_q) > MAX_LOG2) begin
			l_eff = LW'(MAX_LOG2);
		end else begin
			l_eff = LW'(size_q);
		end
	end

	assign nbit  = (AW + 1)'(1) << l_eff;
	assign nmask = nbit[AW-1:0] - AW'(1);
	assign tbit  = (TWA + 1)'(1) << (l_eff - LW'(1));
	assign twm   = tbit[TWA-1:0] - TWA'(1);

	assign action       = s_tuser;
	assign in_word.re   = s_tdata[41:10];
	assign in_word.im   = s_tdata[73:42];
	assign smp_word.re  = s_tdata[41:10];
	assign smp_word.im  = '0;

	// The full index is gathered first, then mirrored end to end.
	always_comb begin
		for (int i = 0; i < AW; i++) begin
			idx_a[i] = (i < 10) ? s_tdata[i] : 1'b0;
		end
		for (int i = 0; i < AW; i++) begin
			idx_rev[i] = idx_a[AW - 1 - i];
		end
	end

	assign smp_addr   = idx_rev >> (AW'(AW) - AW'(l_eff));
	assign bin_addr   = idx_a & nmask;
	assign tw_wr_addr = idx_a[TWA-1:0] & twm;

	// Butterfly addressing: butterfly b of stage s, half = 2^(s-1).
	assign hbit    = AW'(1) << (stage_q - LW'(1));
	assign hm      = hbit - AW'(1);
	assign bx      = AW'(bfly_q);
	assign jv      = bx & hm;
	assign ei      = ((bx & ~hm) << 1) | jv;
	assign oi      = ei | hbit;
	assign tw_full = jv << (l_eff - stage_q);
	assign tw_rd_addr = tw_full[TWA-1:0];
	assign last_bfly  = (bx == (nmask >> 1));

	assign s_tready = (st_q == ST_IDLE) && !rd_pend_q && !hold_v_q;
	assign acc      = s_tvalid && s_tready;

	assign rda_addr = (st_q == ST_IDLE) ? bin_addr : ei;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = smp_addr;
		wr_data = smp_word;
		if (st_q == ST_WE) begin
			wr_en   = 1'b1;
			wr_addr = ei;
			wr_data = bf_even;
		end else if (st_q == ST_WO) begin
			wr_en   = 1'b1;
			wr_addr = oi;
			wr_data = bf_odd;
		end else if (acc && action == r2fft_pkg::ACT_SAMPLE) begin
			wr_en = 1'b1;
		end
	end

	// Memories: one write port, registered reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			data_mem[wr_addr] <= wr_data;
		end
		if (acc && action == r2fft_pkg::ACT_TWIDDLE) begin
			tw_mem[tw_wr_addr] <= in_word;
		end
		rda_q <= data_mem[rda_addr];
		rdb_q <= data_mem[oi];
		rdw_q <= tw_mem[tw_rd_addr];
	end

	r2fft_bfly u_bfly (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (st_q == ST_WAIT),
		.e_in   (rda_q),
		.o_in   (rdb_q),
		.w_in   (rdw_q),
		.done   (bf_done),
		.even   (bf_even),
		.odd    (bf_odd)
	);

	// Sequencer and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= 4'd10;
			st_q      <= ST_IDLE;
			stage_q   <= LW'(1);
			bfly_q    <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
			end
			rd_pend_q <= acc && action == r2fft_pkg::ACT_READ;
			case (st_q)
				ST_IDLE: begin
					if (acc && action == r2fft_pkg::ACT_RUN) begin
						st_q    <= ST_RD;
						stage_q <= LW'(1);
						bfly_q  <= '0;
					end
				end
				ST_RD:   st_q <= ST_WAIT;
				ST_WAIT: st_q <= ST_MUL;
				ST_MUL: begin
					if (bf_done) begin
						st_q <= ST_WE;
					end
				end
				ST_WE:   st_q <= ST_WO;
				ST_WO: begin
					if (last_bfly) begin
						bfly_q <= '0;
						if (stage_q == l_eff) begin
							st_q <= ST_IDLE;
						end else begin
							stage_q <= stage_q + LW'(1);
							st_q    <= ST_RD;
						end
					end else begin
						bfly_q <= bfly_q + TWA'(1);
						st_q   <= ST_RD;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Output register with one hold slot behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			hold_v_q  <= 1'b0;
		end else begin
			if (rd_pend_q) begin
				if (!m_valid_q || m_tready) begin
					m_valid_q <= 1'b1;
				end else begin
					hold_v_q <= 1'b1;
				end
			end else if (m_valid_q && m_tready) begin
				if (hold_v_q) begin
					hold_v_q <= 1'b0;
				end else begin
					m_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			if (!m_valid_q || m_tready) begin
				out_q <= rda_q;
			end else begin
				hold_q <= rda_q;
			end
		end else if (m_valid_q && m_tready && hold_v_q) begin
			out_q <= hold_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q;

	// A parked result always sits behind a valid output.
	a_hold_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> m_valid_q)
		else $error("hold slot full while output empty");

	// The butterfly unit finishes only while the sequencer waits for it.
	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		bf_done |-> st_q == ST_MUL)
		else $error("butterfly done outside multiply phase");

	// The odd write always follows the even write of the same butterfly.
	a_odd_after_even: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_WE |=> st_q == ST_WO && $stable(bfly_q) && $stable(stage_q))
		else $error("odd write not paired with even write");

endmodule

/* verif/tb_radix2_fixed_point_fft_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the radix-2 fixed-point FFT unit.
// Depends on r2fft_pkg and radix2_fixed_point_fft_unit, which in turn needs r2fft_bfly.
module tb_radix2_fixed_point_fft_unit;
	import r2fft_pkg::*;

	localparam int MAX_L = 10;
	localparam int DEPTH = 1 << MAX_L;
	localparam int TW_DEPTH = 1 << (MAX_L - 1);
	localparam int TARGET_ITEMS = 950;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam logic [31:0] NEG_ONE_Q10 = -32'sd1024;

	// Kinds of rows in the directed table.
	typedef enum logic [1:0] {ROW_REQ, ROW_CHECK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  act;
		logic [9:0]  idx;
		logic [31:0] re;
		logic [31:0] im;
		logic [31:0] exp_re;
		logic [31:0] exp_im;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;

	// Shadow copy of the unit's memories and its size register.
	logic [31:0] data_re [DEPTH];
	logic [31:0] data_im [DEPTH];
	logic [31:0] tw_re [TW_DEPTH];
	logic [31:0] tw_im [TW_DEPTH];
	bit          data_written [DEPTH];
	bit          tw_written [TW_DEPTH];
	logic [3:0]  size_reg;

	cword_t      pending_bins [$];
	int          mismatches;
	int          items_sent;
	longint      cycles = 0;
	bit          no_idle;

	radix2_fixed_point_fft_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The run is cut off if it hangs; this bound is far above the slowest correct run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Effective log2 size: zero counts as one, anything above the maximum as the maximum.
	function automatic int eff_log2();
		if (size_reg < 1) return 1;
		if (size_reg > MAX_L) return MAX_L;
		return int'(size_reg);
	endfunction

	function automatic logic [9:0] bit_reverse(logic [9:0] v, int bits);
		logic [9:0] r;
		r = '0;
		for (int i = 0; i < bits; i++) r = {r[8:0], v[i]};
		return r;
	endfunction

	// Q10 product: exact 64-bit product, arithmetic shift by 10, low 32 bits kept.
	function automatic logic [31:0] mul_q10(logic [31:0] a, logic [31:0] b);
		longint p;
		p = longint'($signed(a)) * longint'($signed(b));
		p = p >>> FRAC_BITS;
		return p[31:0];
	endfunction

	function automatic cword_t cmul_q10(cword_t a, cword_t b);
		cword_t r;
		r.re = mul_q10(a.re, b.re) - mul_q10(a.im, b.im);
		r.im = mul_q10(a.re, b.im) + mul_q10(a.im, b.re);
		return r;
	endfunction

	// In-place decimation-in-time passes over the shadow data store.
	task automatic transform_in_place();
		int l, n, m, half, step;
		cword_t w, nw, e, o, neg, t;
		l = eff_log2();
		n = 1 << l;
		neg.re = NEG_ONE_Q10;
		neg.im = '0;
		for (int s = 1; s <= l; s++) begin
			m = 1 << s;
			half = m >> 1;
			step = n >> s;
			for (int k = 0; k < n; k += m) begin
				for (int j = 0; j < half; j++) begin
					w.re = tw_re[(j * step) % TW_DEPTH];
					w.im = tw_im[(j * step) % TW_DEPTH];
					e.re = data_re[k + j];
					e.im = data_im[k + j];
					o.re = data_re[k + j + half];
					o.im = data_im[k + j + half];
					nw = cmul_q10(neg, w);
					t = cmul_q10(w, o);
					data_re[k + j] = e.re + t.re;
					data_im[k + j] = e.im + t.im;
					t = cmul_q10(nw, o);
					data_re[k + j + half] = e.re + t.re;
					data_im[k + j + half] = e.im + t.im;
				end
			end
		end
	endtask

	// Updates the shadow state for one accepted request; a read returns its bin.
	task automatic apply_request(input logic [1:0] act, input logic [9:0] idx,
			input logic [31:0] re, input logic [31:0] im, output bit has_bin,
			output cword_t bin);
		int l, a;
		l = eff_log2();
		has_bin = 1'b0;
		bin = '0;
		case (act)
			ACT_TWIDDLE: begin
				a = idx & ((1 << (l - 1)) - 1);
				tw_re[a] = re;
				tw_im[a] = im;
				tw_written[a] = 1'b1;
			end
			ACT_SAMPLE: begin
				a = bit_reverse(idx & ((1 << l) - 1), l);
				data_re[a] = re;
				data_im[a] = '0;
				data_written[a] = 1'b1;
			end
			ACT_RUN: begin
				transform_in_place();
			end
			default: begin
				a = idx & ((1 << l) - 1);
				bin.re = data_re[a];
				bin.im = data_im[a];
				has_bin = 1'b1;
			end
		endcase
	endtask

	// Random gap, mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sends one request and records what it should produce. A fixed expectation
	// replaces the predicted bin for rows whose answer is typed in.
	task automatic send(input logic [1:0] act, input logic [9:0] idx, input logic [31:0] re,
			input logic [31:0] im, input bit fixed, input cword_t fixed_bin);
		int gap;
		bit has_bin;
		cword_t bin;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {6'b0, im, re, idx};
		do @(posedge clk); while (!s_tready);
		apply_request(act, idx, re, im, has_bin, bin);
		if (has_bin) pending_bins.push_back(fixed ? fixed_bin : bin);
		items_sent++;
	endtask

	task automatic send_pred(input logic [1:0] act, input logic [9:0] idx,
			input logic [31:0] re, input logic [31:0] im);
		send(act, idx, re, im, 1'b0, '0);
	endtask

	// Waits until the unit has nothing left in flight. A run holds s_tready low
	// while it works, so waiting for s_tready covers a run with no read after it.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_bins.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		while (!s_tready) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_size(input logic [3:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_reg = v;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 2048) - 1024;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return $urandom_range(0, 1) ? ($urandom >> 12) : -($urandom >> 12);
		endcase
	endfunction

	// Picks a bin index whose address holds a written entry, or -1 if none does.
	function automatic int pick_read_index();
		int idx, nmask;
		nmask = (1 << eff_log2()) - 1;
		for (int t = 0; t < 64; t++) begin
			idx = $urandom_range(0, 1023);
			if (data_written[idx & nmask]) return idx;
		end
		for (int a = 0; a <= nmask; a++) if (data_written[a]) return a;
		return -1;
	endfunction

	// A run only reads what the current size covers; all of it must be loaded.
	function automatic bit run_allowed();
		int l;
		l = eff_log2();
		for (int a = 0; a < (1 << l); a++) if (!data_written[a]) return 1'b0;
		for (int a = 0; a < (1 << (l - 1)); a++) if (!tw_written[a]) return 1'b0;
		return 1'b1;
	endfunction

	task automatic read_random();
		int idx;
		idx = pick_read_index();
		if (idx >= 0) send_pred(ACT_READ, idx[9:0], $urandom, $urandom);
	endtask

	// One load-transform-read sequence. Index bits above the size are random so
	// the wrap of every index is exercised; noise requests are mixed in.
	task automatic run_phase(input logic [3:0] raw_size, input bit do_run);
		int l, n, idx, reads;
		set_size(raw_size);
		l = eff_log2();
		n = 1 << l;
		for (int a = 0; a < n / 2; a++) begin
			idx = a | ($urandom_range(0, 1023) << (l - 1));
			send_pred(ACT_TWIDDLE, idx[9:0], rand_value(), rand_value());
		end
		for (int a = 0; a < n; a++) begin
			idx = a | ($urandom_range(0, 1023) << l);
			send_pred(ACT_SAMPLE, idx[9:0], rand_value(), rand_value());
			if ($urandom_range(0, 7) == 0) read_random();
		end
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 2))
				0: send_pred(ACT_TWIDDLE, 10'($urandom), rand_value(), rand_value());
				1: send_pred(ACT_SAMPLE, 10'($urandom), rand_value(), rand_value());
				default: read_random();
			endcase
		end
		if (do_run && run_allowed()) begin
			send_pred(ACT_RUN, 10'($urandom), $urandom, $urandom);
			if ($urandom_range(0, 3) == 0 && run_allowed())
				send_pred(ACT_RUN, 10'($urandom), $urandom, $urandom);
		end
		reads = $urandom_range(2, (n < 16) ? n + 2 : 16);
		repeat (reads) read_random();
	endtask

	task automatic note_mismatch(input cword_t want, input cword_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("bin mismatch: expected re=%h im=%h, got re=%h im=%h",
				want.re, want.im, got.re, got.im);
	endtask

	// Every accepted result is compared with the oldest expected bin.
	always @(posedge clk) begin
		cword_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.re = m_tdata[31:0];
			got.im = m_tdata[63:32];
			if (pending_bins.size() == 0) begin
				note_mismatch('x, got);
			end else begin
				want = pending_bins.pop_front();
				if (got.re !== want.re || got.im !== want.im) note_mismatch(want, got);
			end
		end
	end

	// Receiver: bursts of readiness broken by stalls, mostly short, a few long.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Directed rows: extremes after reset, the smallest size with a hand-worked
	// butterfly, sizes out of range, and index wrap for twiddle, sample and read requests.
	row_t dir_rows [] = '{
		'{ROW_REQ,   ACT_SAMPLE,  10'd1,    32'h7fff_ffff, 32'h0,         0, 0},
		'{ROW_CHECK, ACT_READ,    10'd512,  32'h0,         32'h0,         32'h7fff_ffff, 0},
		'{ROW_REQ,   ACT_SAMPLE,  10'd0,    32'h8000_0000, 32'hffff_ffff, 0, 0},
		'{ROW_CHECK, ACT_READ,    10'd0,    32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 0},
		'{ROW_REQ,   ACT_SAMPLE,  10'd1023, 32'h400,       32'h0,         0, 0},
		'{ROW_CHECK, ACT_READ,    10'd1023, 32'h0,         32'h0,         32'h400, 0},
		'{ROW_REQ,   ACT_TWIDDLE, 10'd1023, 32'h7fff_ffff, 32'h8000_0000, 0, 0},
		'{ROW_REQ,   ACT_TWIDDLE, 10'd511,  32'h8000_0000, 32'h7fff_ffff, 0, 0},
		'{ROW_CFG,   ACT_TWIDDLE, 10'd1,    0, 0, 0, 0},
		'{ROW_REQ,   ACT_TWIDDLE, 10'd0,    32'h400,       32'h0,         0, 0},
		'{ROW_REQ,   ACT_SAMPLE,  10'd0,    32'hc00,       32'h1234,      0, 0},
		'{ROW_REQ,   ACT_SAMPLE,  10'd1,    32'h400,       32'h0,         0, 0},
		'{ROW_REQ,   ACT_RUN,     10'd0,    32'h0,         32'h0,         0, 0},
		'{ROW_CHECK, ACT_READ,    10'd0,    32'h0,         32'h0,         32'h1000, 0},
		'{ROW_CHECK, ACT_READ,    10'd3,    32'h0,         32'h0,         32'h800, 0},
		'{ROW_CFG,   ACT_TWIDDLE, 10'd0,    0, 0, 0, 0},
		'{ROW_REQ,   ACT_TWIDDLE, 10'd1,    32'h0,         32'h400,       0, 0},
		'{ROW_REQ,   ACT_SAMPLE,  10'd2,    32'h400,       32'h0,         0, 0},
		'{ROW_REQ,   ACT_SAMPLE,  10'd1,    32'hffff_fc00, 32'h0,         0, 0},
		'{ROW_REQ,   ACT_RUN,     10'd1023, 32'hffff_ffff, 32'hffff_ffff, 0, 0},
		'{ROW_REQ,   ACT_READ,    10'd0,    32'h0,         32'h0,         0, 0},
		'{ROW_REQ,   ACT_READ,    10'd1,    32'h0,         32'h0,         0, 0},
		'{ROW_CFG,   ACT_TWIDDLE, 10'd15,   0, 0, 0, 0},
		'{ROW_REQ,   ACT_SAMPLE,  10'd1,    32'h5,         32'h0,         0, 0},
		'{ROW_CHECK, ACT_READ,    10'd512,  32'h0,         32'h0,         32'h5, 0}
	};

	initial begin
		cword_t fixed_bin;
		logic [3:0] raw;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_TWIDDLE;
		mismatches = 0;
		items_sent = 0;
		no_idle = 1'b0;
		size_reg = 4'd10;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			case (dir_rows[r].kind)
				ROW_CFG: set_size(dir_rows[r].idx[3:0]);
				ROW_CHECK: begin
					fixed_bin.re = dir_rows[r].exp_re;
					fixed_bin.im = dir_rows[r].exp_im;
					send(dir_rows[r].act, dir_rows[r].idx, dir_rows[r].re, dir_rows[r].im,
						1'b1, fixed_bin);
				end
				default: send_pred(dir_rows[r].act, dir_rows[r].idx, dir_rows[r].re,
					dir_rows[r].im);
			endcase
		end

		// Random phases, mostly small sizes; now and then one without a run or
		// without idling. Every phase starts with a pause until all bins are back.
		while (items_sent < TARGET_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: raw = 4'd0;
				1: raw = 4'd1;
				2: raw = 4'd6;
				default: raw = $urandom_range(1, 5);
			endcase
			run_phase(raw, $urandom_range(0, 5) != 0);
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
